/* hw/rtl/scdt_pkg.sv */
// shared types and constants for the serial command tokenizer and dispatcher
package scdt_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REG,
        S_LOOK,
        S_HEAD,
        S_ARGS,
        S_ARG_WR
    } t_state;

    localparam logic [1:0] REQ_REG  = 2'd0;
    localparam logic [1:0] REQ_BYTE = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    localparam logic [1:0] KIND_REG  = 2'd0;
    localparam logic [1:0] KIND_HEAD = 2'd1;
    localparam logic [1:0] KIND_ARG  = 2'd2;

    localparam logic [0:0] CFG_TIMEOUT = 1'b0;
    localparam logic [0:0] CFG_LIMIT   = 1'b1;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    localparam logic [2:0]  FIELD_SAT  = 3'd7;
    localparam logic [15:0] IDLE_SAT   = 16'hffff;
    localparam logic [4:0]  LIMIT_INIT = 5'd16;

    typedef struct packed {
        logic [1:0]  kind;
        logic        success;
        logic [3:0]  index;
        logic [2:0]  count;
        logic [63:0] text;
        logic [3:0]  length;
        logic        truncated;
        logic        last;
    } t_result;

endpackage

/* hw/rtl/scdt_ram.sv */
// generic single-port-write, registered-read memory
module scdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/scdt_outbuf.sv */
// result output register with valid and stall handshake
module scdt_outbuf
    import scdt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* hw/rtl/serial_command_tokenizer_dispatch.sv */
// top level: line tokenizer, name table lookup and result sequencing
// A request is a name registration, a received byte or a millisecond tick. Registration
// passes through S_REG, which loads its result; a tick, a delimiter or a command byte is
// handled in S_IDLE; an argument byte also passes through S_ARG_WR (read-modify-write of
// the argument memory). A newline walks the name table's single read port in S_LOOK,
// one entry per cycle, then sends a head result in S_HEAD and one per argument in S_ARGS.
// Each result waits in an output register, so bytes keep being taken while a result is
// stalled. There is no clearing pass after reset; unwritten table entries are never read.
module serial_command_tokenizer_dispatch
    import scdt_pkg::*;
#(
    parameter int MAX_ARGS    = 4,
    parameter int TABLE_DEPTH = 16,
    parameter int TEXT_BYTES  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic [63:0] i_name_chars,
    input  logic [3:0]  i_name_length,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic        o_success,
    output logic [3:0]  o_handler_index,
    output logic [2:0]  o_arg_count,
    output logic [63:0] o_arg_text,
    output logic [3:0]  o_arg_length,
    output logic        o_arg_truncated,
    output logic        o_last_of_run
);

    localparam int TW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ECW = $clog2(TABLE_DEPTH + 1);
    localparam int AW  = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    localparam int TXW = TEXT_BYTES * 8;
    localparam int EW  = TXW + 4;
    localparam int LW  = (ECW > 5) ? ECW : 5;

    t_state               r_state, n_state;
    logic [15:0]          r_timeout, n_timeout;
    logic [4:0]           r_limit, n_limit;
    logic [2:0]           r_field, n_field;
    logic [TXW-1:0]       r_cmd_buf, n_cmd_buf;
    logic [3:0]           r_cmd_len, n_cmd_len;
    logic                 r_cmd_ovf, n_cmd_ovf;
    logic [MAX_ARGS-1:0]  r_arg_vld, n_arg_vld;
    logic [15:0]          r_idle, n_idle;
    logic [ECW-1:0]       r_entry_count, n_entry_count;
    logic [TW-1:0]        r_scan, n_scan;
    logic                 r_found, n_found;
    logic [TW-1:0]        r_idx, n_idx;
    logic [2:0]           r_cnt, n_cnt;
    logic [AW-1:0]        r_argi, n_argi;
    logic [7:0]           r_byte, n_byte;
    logic [AW-1:0]        r_arg_addr, n_arg_addr;
    logic                 r_reg_ok, n_reg_ok;
    logic [TW-1:0]        r_reg_idx, n_reg_idx;

    logic                 tbl_we, tbl_re;
    logic [TW-1:0]        tbl_waddr, tbl_raddr;
    logic [EW-1:0]        tbl_wdata, tbl_rdata;
    logic                 arg_we, arg_re;
    logic [AW-1:0]        arg_waddr, arg_raddr;
    logic [EW-1:0]        arg_wdata, arg_rdata;

    logic                 out_load, out_free, out_valid;
    t_result              out_res, out_q;

    logic [3:0]           name_len;
    logic [TXW-1:0]       name_text;
    logic [LW-1:0]        lim;
    logic                 tbl_full;
    logic                 in_acc;
    logic                 pending;
    logic [EW-1:0]        arg_cur;
    logic [3:0]           arg_cur_len;
    logic                 tbl_match;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        name_len  = (i_name_length > 4'(TEXT_BYTES)) ? 4'(TEXT_BYTES) : i_name_length;
        name_text = '0;
        for (int k = 0; k < TEXT_BYTES; k++) begin
            if (k < int'(name_len)) begin
                name_text[k*8 +: 8] = i_name_chars[k*8 +: 8];
            end
        end
        lim = (LW'(r_limit) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(r_limit);
        tbl_full = (LW'(r_entry_count) >= lim);
        pending = (r_field != 3'd0) || (r_cmd_len != 4'd0) || r_cmd_ovf;
        arg_cur = r_arg_vld[r_arg_addr] ? arg_rdata : '0;
        if (r_state == S_ARGS) begin
            arg_cur = r_arg_vld[r_argi] ? arg_rdata : '0;
        end
        arg_cur_len = arg_cur[EW-1 -: 4];
        tbl_match = (tbl_rdata[EW-1 -: 4] == r_cmd_len) && (tbl_rdata[TXW-1:0] == r_cmd_buf);
    end

    always_comb begin
        n_state       = r_state;
        n_timeout     = r_timeout;
        n_limit       = r_limit;
        n_field       = r_field;
        n_cmd_buf     = r_cmd_buf;
        n_cmd_len     = r_cmd_len;
        n_cmd_ovf     = r_cmd_ovf;
        n_arg_vld     = r_arg_vld;
        n_idle        = r_idle;
        n_entry_count = r_entry_count;
        n_scan        = r_scan;
        n_found       = r_found;
        n_idx         = r_idx;
        n_cnt         = r_cnt;
        n_argi        = r_argi;
        n_byte        = r_byte;
        n_arg_addr    = r_arg_addr;
        n_reg_ok      = r_reg_ok;
        n_reg_idx     = r_reg_idx;
        tbl_we        = 1'b0;
        tbl_waddr     = r_entry_count[TW-1:0];
        tbl_wdata     = {name_len, name_text};
        tbl_re        = 1'b0;
        tbl_raddr     = '0;
        arg_we        = 1'b0;
        arg_waddr     = r_arg_addr;
        arg_wdata     = arg_cur;
        arg_re        = 1'b0;
        arg_raddr     = '0;
        out_load      = 1'b0;
        out_res       = '0;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT: n_timeout = i_cfg_data;
                CFG_LIMIT:   n_limit   = i_cfg_data[4:0];
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_req_type)
                        REQ_REG: begin
                            n_state = S_REG;
                            if (tbl_full) begin
                                n_reg_ok  = 1'b0;
                                n_reg_idx = '0;
                            end else begin
                                tbl_we        = 1'b1;
                                n_reg_ok      = 1'b1;
                                n_reg_idx     = r_entry_count[TW-1:0];
                                n_entry_count = r_entry_count + 1'b1;
                            end
                        end
                        REQ_BYTE: begin
                            n_idle = '0;
                            priority if (i_data_byte == CH_SPACE || i_data_byte == CH_COMMA) begin
                                if (r_field != FIELD_SAT) begin
                                    n_field = r_field + 3'd1;
                                end
                            end else if (i_data_byte == CH_NEWLINE) begin
                                n_cnt   = (r_field > 3'(MAX_ARGS)) ? 3'(MAX_ARGS) : r_field;
                                n_found = 1'b0;
                                n_idx   = '0;
                                n_scan  = '0;
                                if (!r_cmd_ovf && r_entry_count != '0) begin
                                    tbl_re  = 1'b1;
                                    n_state = S_LOOK;
                                end else begin
                                    n_state = S_HEAD;
                                end
                            end else if (r_field == 3'd0) begin
                                if (r_cmd_len < 4'(TEXT_BYTES)) begin
                                    for (int k = 0; k < TEXT_BYTES; k++) begin
                                        if (k == int'(r_cmd_len)) begin
                                            n_cmd_buf[k*8 +: 8] = i_data_byte;
                                        end
                                    end
                                    n_cmd_len = r_cmd_len + 4'd1;
                                end else begin
                                    n_cmd_ovf = 1'b1;
                                end
                            end else if (r_field <= 3'(MAX_ARGS)) begin
                                arg_re     = 1'b1;
                                arg_raddr  = AW'(r_field - 3'd1);
                                n_arg_addr = AW'(r_field - 3'd1);
                                n_byte     = i_data_byte;
                                n_state    = S_ARG_WR;
                            end else begin
                                // bytes of fields past the last argument are dropped
                            end
                        end
                        REQ_TICK: begin
                            if (r_timeout != '0 && pending && r_idle >= r_timeout) begin
                                n_field   = '0;
                                n_cmd_buf = '0;
                                n_cmd_len = '0;
                                n_cmd_ovf = 1'b0;
                                n_arg_vld = '0;
                                n_idle    = '0;
                            end else if (r_idle != IDLE_SAT) begin
                                n_idle = r_idle + 16'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ARG_WR: begin
                arg_we = 1'b1;
                if (arg_cur_len < 4'(TEXT_BYTES)) begin
                    for (int k = 0; k < TEXT_BYTES; k++) begin
                        if (k == int'(arg_cur_len)) begin
                            arg_wdata[k*8 +: 8] = r_byte;
                        end
                    end
                    arg_wdata[EW-1 -: 4] = arg_cur_len + 4'd1;
                end else begin
                    arg_wdata[EW-1 -: 4] = 4'(TEXT_BYTES + 1);
                end
                n_arg_vld[r_arg_addr] = 1'b1;
                n_state = S_IDLE;
            end
            S_REG: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_res.kind    = KIND_REG;
                    out_res.success = r_reg_ok;
                    out_res.index   = 4'(r_reg_idx);
                    out_res.last    = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_LOOK: begin
                if (tbl_match) begin
                    n_found = 1'b1;
                    n_idx   = r_scan;
                    n_state = S_HEAD;
                end else if (ECW'(r_scan) + 1'b1 >= r_entry_count) begin
                    n_state = S_HEAD;
                end else begin
                    n_scan    = r_scan + 1'b1;
                    tbl_re    = 1'b1;
                    tbl_raddr = r_scan + 1'b1;
                end
            end
            S_HEAD: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_res.kind    = KIND_HEAD;
                    out_res.success = r_found;
                    out_res.index   = 4'(r_idx);
                    out_res.count   = r_cnt;
                    out_res.last    = !(r_found && r_cnt != 3'd0);
                    if (r_found && r_cnt != 3'd0) begin
                        arg_re  = 1'b1;
                        n_argi  = '0;
                        n_state = S_ARGS;
                    end else begin
                        n_field   = '0;
                        n_cmd_buf = '0;
                        n_cmd_len = '0;
                        n_cmd_ovf = 1'b0;
                        n_arg_vld = '0;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_ARGS: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    out_res.kind      = KIND_ARG;
                    out_res.success   = 1'b1;
                    out_res.index     = 4'(r_idx);
                    out_res.count     = r_cnt;
                    out_res.text      = 64'(arg_cur[TXW-1:0]);
                    out_res.truncated = (arg_cur_len > 4'(TEXT_BYTES));
                    out_res.length    = out_res.truncated ? 4'(TEXT_BYTES) : arg_cur_len;
                    out_res.last      = (3'(r_argi) + 3'd1 == r_cnt);
                    if (out_res.last) begin
                        n_field   = '0;
                        n_cmd_buf = '0;
                        n_cmd_len = '0;
                        n_cmd_ovf = 1'b0;
                        n_arg_vld = '0;
                        n_state   = S_IDLE;
                    end else begin
                        n_argi    = r_argi + 1'b1;
                        arg_re    = 1'b1;
                        arg_raddr = r_argi + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_timeout     <= '0;
            r_limit       <= LIMIT_INIT;
            r_field       <= '0;
            r_cmd_buf     <= '0;
            r_cmd_len     <= '0;
            r_cmd_ovf     <= 1'b0;
            r_arg_vld     <= '0;
            r_idle        <= '0;
            r_entry_count <= '0;
            r_scan        <= '0;
            r_found       <= 1'b0;
            r_idx         <= '0;
            r_cnt         <= '0;
            r_argi        <= '0;
        end else begin
            r_state       <= n_state;
            r_timeout     <= n_timeout;
            r_limit       <= n_limit;
            r_field       <= n_field;
            r_cmd_buf     <= n_cmd_buf;
            r_cmd_len     <= n_cmd_len;
            r_cmd_ovf     <= n_cmd_ovf;
            r_arg_vld     <= n_arg_vld;
            r_idle        <= n_idle;
            r_entry_count <= n_entry_count;
            r_scan        <= n_scan;
            r_found       <= n_found;
            r_idx         <= n_idx;
            r_cnt         <= n_cnt;
            r_argi        <= n_argi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_arg_addr <= n_arg_addr;
        r_reg_ok   <= n_reg_ok;
        r_reg_idx  <= n_reg_idx;
    end

    scdt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_name_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    scdt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ARGS)
    ) u_arg_mem (
        .i_clk   (i_clk),
        .i_we    (arg_we),
        .i_waddr (arg_waddr),
        .i_wdata (arg_wdata),
        .i_re    (arg_re),
        .i_raddr (arg_raddr),
        .o_rdata (arg_rdata)
    );

    scdt_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_result (out_res),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (out_valid),
        .o_result (out_q)
    );

    assign o_out_valid     = out_valid;
    assign o_result_kind   = out_q.kind;
    assign o_success       = out_q.success;
    assign o_handler_index = out_q.index;
    assign o_arg_count     = out_q.count;
    assign o_arg_text      = out_q.text;
    assign o_arg_length    = out_q.length;
    assign o_arg_truncated = out_q.truncated;
    assign o_last_of_run   = out_q.last;

    // table walk stays inside the filled part and only for a short command
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> ((ECW'(r_scan) < r_entry_count) && !r_cmd_ovf))
        else $error("table walk out of range");

    // an accepted registration with room grows the table by one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == REQ_REG && !tbl_full)
        |=> (r_entry_count == ECW'($past(r_entry_count) + 1'b1)))
        else $error("entry count not advanced");

    // argument results follow only a found command with arguments
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ARGS) |-> (r_found && r_cnt != 3'd0))
        else $error("argument results without a match");

    // a result is loaded only when the output register can take it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && i_out_stall && out_load) |-> 1'b0)
        else $error("stalled result overwritten");

endmodule
